// File: hw/rtl/foa_pkg.sv
`timescale 1ns / 1ps
package foa_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned AREA_W   = 63;
  localparam int unsigned ANG_W    = 15;
  localparam int unsigned NMAG_W   = 65;   // normal component magnitude, widest coordinates
  localparam int unsigned DZ_W     = 34;
  localparam int unsigned ACC_W    = 134;  // sum of three squared magnitudes
  localparam int unsigned RAD_W    = 100;
  localparam int unsigned ROOT_W   = 50;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned AREA_SHIFT = 34;
  localparam int unsigned FOOT_SHIFT = 17;
  localparam int unsigned NORM_MSB = 30;
  localparam int unsigned CX_W     = 34;
  localparam int unsigned CZ_W     = 25;
  localparam int unsigned TAB_W    = 22;
  localparam int unsigned CORDIC_N = 23;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic signed [DZ_W-1:0] BED_TOL = DZ_W'(7);
  localparam logic [ANG_W-1:0] ANGLE_MAX   = ANG_W'(23040);
  localparam logic [ANG_W-1:0] STEEP_LIMIT = ANG_W'(17920);
  localparam logic [ANG_W-1:0] LIMIT_RESET = ANG_W'(11520);

  localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_N] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERHANG_LIMIT = 1'b0,
    CFG_BED_Z          = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by_coord;
    logic signed [IN_W-1:0] bz;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
    logic signed [IN_W-1:0] cz;
    logic                   last_facet;
  } facet_in_t;

  typedef struct packed {
    logic [AREA_W-1:0] surf_total;
    logic [AREA_W-1:0] ovh_total;
    logic [AREA_W-1:0] steep_total;
    logic [AREA_W-1:0] foot_total;
    logic [ANG_W-1:0]  max_overhang;
  } facet_out_t;

  // classified facet handed from the front end to the back end
  typedef struct packed {
    logic [NMAG_W-1:0] nx_mag;
    logic [NMAG_W-1:0] ny_mag;
    logic [NMAG_W-1:0] nz_mag;
    logic              nz_neg;
    logic              on_bed;
    logic              last;
  } facet_t;

  function automatic logic [AREA_W-1:0] sat_add(logic [AREA_W-1:0] a, logic [AREA_W-1:0] b);
    logic [AREA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_W] ? {AREA_W{1'b1}} : s[AREA_W-1:0];
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [CX_W-1:0] shr_tz(logic signed [CX_W-1:0] v, logic [4:0] sh);
    logic [CX_W-1:0] m;
    m = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
    m = m >> sh;
    return v[CX_W-1] ? signed'(CX_W'(-m)) : signed'(m);
  endfunction

endpackage

// File: hw/rtl/foa_front.sv
`timescale 1ns / 1ps
module foa_front import foa_pkg::*; #(
  parameter int unsigned CoordWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  facet_in_t              in_data_i,
  input  logic signed [IN_W-1:0] bed_z_i,
  input  logic                   full_i,
  output logic                   push_o,
  output facet_t                 entry_o
);

  localparam int unsigned EW = CoordWidth + 1;
  localparam int unsigned PW = 2 * CoordWidth;
  localparam int unsigned MW = PW + 1;

  logic en;
  logic v1_q, v2_q, v3_q;

  logic signed [CoordWidth-1:0] p [9];
  logic signed [EW-1:0]         e [6];
  logic [CoordWidth-1:0]        mag_d [6];
  logic [5:0]                   sgn_d;
  logic signed [DZ_W-1:0]       dz [3];
  logic                         bed_d;

  logic [CoordWidth-1:0] mag_q [6];
  logic [5:0]            sgn_q;
  logic                  bed1_q, last1_q;

  logic [PW-1:0] prod_d [6];
  logic [2:0]    sa_d, sb_d;
  logic [PW-1:0] prod_q [6];
  logic [2:0]    sa_q, sb_q;
  logic          bed2_q, last2_q;

  logic [MW-1:0] nmag_d [3];
  logic [2:0]    nneg_d;
  logic [MW-1:0] nmag_q [3];
  logic          nzneg_q, bed3_q, last3_q;

  assign en         = !v3_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = v3_q && !full_i;

  // edges b-a and c-a, their magnitudes and signs, bed contact
  always_comb begin
    p[0] = in_data_i.ax[CoordWidth-1:0];
    p[1] = in_data_i.ay[CoordWidth-1:0];
    p[2] = in_data_i.az[CoordWidth-1:0];
    p[3] = in_data_i.bx[CoordWidth-1:0];
    p[4] = in_data_i.by_coord[CoordWidth-1:0];
    p[5] = in_data_i.bz[CoordWidth-1:0];
    p[6] = in_data_i.cx[CoordWidth-1:0];
    p[7] = in_data_i.cy[CoordWidth-1:0];
    p[8] = in_data_i.cz[CoordWidth-1:0];
    for (int k = 0; k < 3; k++) begin
      e[k]     = EW'(p[3+k]) - EW'(p[k]);
      e[3+k]   = EW'(p[6+k]) - EW'(p[k]);
    end
    for (int k = 0; k < 6; k++) begin
      sgn_d[k] = e[k][EW-1];
      mag_d[k] = e[k][EW-1] ? CoordWidth'(-e[k]) : CoordWidth'(e[k]);
    end
    for (int k = 0; k < 3; k++) begin
      dz[k] = DZ_W'(p[3*k+2]) - DZ_W'(bed_z_i);
    end
    bed_d = (dz[0] < BED_TOL) && (dz[1] < BED_TOL) && (dz[2] < BED_TOL);
  end

  // n = e1 x e2, each term as p1*q1 - p2*q2
  always_comb begin
    prod_d[0] = PW'(mag_q[1]) * PW'(mag_q[5]);
    prod_d[1] = PW'(mag_q[2]) * PW'(mag_q[4]);
    prod_d[2] = PW'(mag_q[2]) * PW'(mag_q[3]);
    prod_d[3] = PW'(mag_q[0]) * PW'(mag_q[5]);
    prod_d[4] = PW'(mag_q[0]) * PW'(mag_q[4]);
    prod_d[5] = PW'(mag_q[1]) * PW'(mag_q[3]);
    sa_d[0] = sgn_q[1] ^ sgn_q[5];
    sb_d[0] = !(sgn_q[2] ^ sgn_q[4]);
    sa_d[1] = sgn_q[2] ^ sgn_q[3];
    sb_d[1] = !(sgn_q[0] ^ sgn_q[5]);
    sa_d[2] = sgn_q[0] ^ sgn_q[4];
    sb_d[2] = !(sgn_q[1] ^ sgn_q[3]);
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      logic sa, sb;
      sa = sa_q[t] && (prod_q[2*t] != '0);
      sb = sb_q[t] && (prod_q[2*t+1] != '0);
      if (sa == sb) begin
        nmag_d[t] = MW'(prod_q[2*t]) + MW'(prod_q[2*t+1]);
        nneg_d[t] = sa;
      end else if (prod_q[2*t] >= prod_q[2*t+1]) begin
        nmag_d[t] = MW'(prod_q[2*t] - prod_q[2*t+1]);
        nneg_d[t] = sa;
      end else begin
        nmag_d[t] = MW'(prod_q[2*t+1] - prod_q[2*t]);
        nneg_d[t] = sb;
      end
      if (nmag_d[t] == '0) nneg_d[t] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q   <= mag_d;
      sgn_q   <= sgn_d;
      bed1_q  <= bed_d;
      last1_q <= in_data_i.last_facet;
      prod_q  <= prod_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      bed2_q  <= bed1_q;
      last2_q <= last1_q;
      nmag_q  <= nmag_d;
      nzneg_q <= nneg_d[2];
      bed3_q  <= bed2_q;
      last3_q <= last2_q;
    end
  end

  assign entry_o.nx_mag = NMAG_W'(nmag_q[0]);
  assign entry_o.ny_mag = NMAG_W'(nmag_q[1]);
  assign entry_o.nz_mag = NMAG_W'(nmag_q[2]);
  assign entry_o.nz_neg = nzneg_q;
  assign entry_o.on_bed = bed3_q;
  assign entry_o.last   = last3_q;

endmodule

// File: hw/rtl/foa_fifo.sv
`timescale 1ns / 1ps
module foa_fifo import foa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  facet_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output facet_t entry_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  facet_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i && cnt_q == CNT_W'(1)) |=> !valid_o)
    else $error("queue not empty after last entry left");

endmodule

// File: hw/rtl/foa_back.sv
`timescale 1ns / 1ps
module foa_back import foa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  facet_t           entry_i,
  output logic             pop_o,
  input  logic [ANG_W-1:0] limit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output facet_out_t       out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_SQ, B_ROOT, B_ACC, B_NORM, B_HSQ, B_HROOT, B_CORDIC, B_ANG, B_DONE
  } state_e;

  state_e state_q;
  facet_t cur_q;

  logic [ACC_W-1:0]  mul_a_q, acc_q, mul_sum;
  logic [NMAG_W-1:0] mul_b_q;
  logic [1:0]        sel_q;

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q, area_q;
  logic [REM_W-1:0]  rem_q, rem2, trial;
  logic              ge;
  logic [5:0]        cnt_q;

  logic [NMAG_W-1:0] vx_q, vy_q, vz_q;
  logic              any_hi, any_top;

  logic signed [CX_W-1:0] x_q, y_q, xs, ys;
  logic signed [CZ_W-1:0] z_q;
  logic [TAB_W-1:0]       tab;
  logic [CZ_W-1:0]        zr_sum;
  logic [CZ_W-9:0]        zr;
  logic [ANG_W-1:0]       ang;

  logic [AREA_W-1:0] surf_q, over_q, steep_q, foot_q;
  logic [ANG_W-1:0]  max_q;
  logic              out_valid_q;
  facet_out_t        out_q;
  logic              emit;

  assign pop_o       = (state_q == B_IDLE) && fifo_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign emit        = (state_q == B_DONE) && cur_q.last && (!out_valid_q || out_ready_i);

  always_comb begin
    mul_sum = acc_q + (mul_b_q[0] ? mul_a_q : '0);
    rem2    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (rem2 >= trial);
    any_hi  = |{vx_q[NMAG_W-1:NORM_MSB], vy_q[NMAG_W-1:NORM_MSB], vz_q[NMAG_W-1:NORM_MSB]};
    any_top = vx_q[NORM_MSB-1] | vy_q[NORM_MSB-1] | vz_q[NORM_MSB-1];
    tab     = ATAN_TAB[cnt_q[4:0]];
    xs      = shr_tz(x_q, cnt_q[4:0]);
    ys      = shr_tz(y_q, cnt_q[4:0]);
    // clamp at zero, round to 1/256 degree, clamp at the top
    zr_sum  = (z_q[CZ_W-1] ? '0 : CZ_W'(z_q)) + CZ_W'(128);
    zr      = zr_sum[CZ_W-1:8];
    ang     = (zr > (CZ_W-8)'(ANGLE_MAX)) ? ANGLE_MAX : ANG_W'(zr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cur_q       <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      acc_q       <= '0;
      sel_q       <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      rem_q       <= '0;
      area_q      <= '0;
      cnt_q       <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      surf_q      <= '0;
      over_q      <= '0;
      steep_q     <= '0;
      foot_q      <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (fifo_valid_i) begin
            cur_q   <= entry_i;
            mul_a_q <= ACC_W'(entry_i.nx_mag);
            mul_b_q <= entry_i.nx_mag;
            acc_q   <= '0;
            sel_q   <= 2'd0;
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          if (mul_b_q != '0) begin
            acc_q   <= mul_sum;
            mul_a_q <= mul_a_q << 1;
            mul_b_q <= mul_b_q >> 1;
          end else if (sel_q == 2'd0) begin
            mul_a_q <= ACC_W'(cur_q.ny_mag);
            mul_b_q <= cur_q.ny_mag;
            sel_q   <= 2'd1;
          end else if (sel_q == 2'd1) begin
            mul_a_q <= ACC_W'(cur_q.nz_mag);
            mul_b_q <= cur_q.nz_mag;
            sel_q   <= 2'd2;
          end else begin
            rad_q   <= acc_q[ACC_W-1:AREA_SHIFT];
            root_q  <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_ROOT;
          end
        end
        B_ROOT, B_HROOT: begin
          rem_q  <= ge ? rem2 - trial : rem2;
          root_q <= {root_q[ROOT_W-2:0], ge};
          rad_q  <= rad_q << 2;
          cnt_q  <= (cnt_q == 6'(ROOT_W - 1)) ? '0 : cnt_q + 1'b1;
          if (cnt_q == 6'(ROOT_W - 1)) begin
            state_q <= (state_q == B_ROOT) ? B_ACC : B_CORDIC;
            if (state_q == B_HROOT) begin
              x_q   <= signed'(CX_W'({root_q[ROOT_W-2:0], ge}));
              y_q   <= signed'(CX_W'(vz_q));
              z_q   <= '0;
            end
          end
        end
        B_ACC: begin
          area_q <= root_q;
          if (acc_q == '0 || !cur_q.nz_neg) begin
            if (acc_q != '0) surf_q <= sat_add(surf_q, AREA_W'(root_q));
            state_q <= B_DONE;
          end else if (cur_q.on_bed) begin
            surf_q  <= sat_add(surf_q, AREA_W'(root_q));
            foot_q  <= sat_add(foot_q, AREA_W'(cur_q.nz_mag[NMAG_W-1:FOOT_SHIFT]));
            state_q <= B_DONE;
          end else begin
            surf_q  <= sat_add(surf_q, AREA_W'(root_q));
            vx_q    <= cur_q.nx_mag;
            vy_q    <= cur_q.ny_mag;
            vz_q    <= cur_q.nz_mag;
            state_q <= B_NORM;
          end
        end
        B_NORM: begin
          // scale all three until the largest sits just below bit 30
          if (any_hi) begin
            vx_q <= vx_q >> 1;
            vy_q <= vy_q >> 1;
            vz_q <= vz_q >> 1;
          end else if (!any_top) begin
            vx_q <= vx_q << 1;
            vy_q <= vy_q << 1;
            vz_q <= vz_q << 1;
          end else begin
            mul_a_q <= ACC_W'(vx_q);
            mul_b_q <= vx_q;
            acc_q   <= '0;
            sel_q   <= 2'd0;
            state_q <= B_HSQ;
          end
        end
        B_HSQ: begin
          if (mul_b_q != '0) begin
            acc_q   <= mul_sum;
            mul_a_q <= mul_a_q << 1;
            mul_b_q <= mul_b_q >> 1;
          end else if (sel_q == 2'd0) begin
            mul_a_q <= ACC_W'(vy_q);
            mul_b_q <= vy_q;
            sel_q   <= 2'd1;
          end else begin
            rad_q   <= RAD_W'(acc_q);
            root_q  <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_HROOT;
          end
        end
        B_CORDIC: begin
          if (!y_q[CX_W-1]) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + signed'(CZ_W'(tab));
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - signed'(CZ_W'(tab));
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(CORDIC_N - 1)) state_q <= B_ANG;
        end
        B_ANG: begin
          if (ang > max_q)       max_q   <= ang;
          if (ang > limit_i)     over_q  <= sat_add(over_q, AREA_W'(area_q));
          if (ang > STEEP_LIMIT) steep_q <= sat_add(steep_q, AREA_W'(area_q));
          state_q <= B_DONE;
        end
        B_DONE: begin
          if (!cur_q.last) begin
            state_q <= B_IDLE;
          end else if (emit) begin
            out_q.surf_total   <= surf_q;
            out_q.ovh_total    <= over_q;
            out_q.steep_total  <= steep_q;
            out_q.foot_total   <= foot_q;
            out_q.max_overhang <= max_q;
            surf_q  <= '0;
            over_q  <= '0;
            steep_q <= '0;
            foot_q  <= '0;
            max_q   <= '0;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_cordic_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CORDIC) |-> (cnt_q < 6'(CORDIC_N)))
    else $error("cordic step count overrun");

  a_max_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q <= ANGLE_MAX)
    else $error("largest angle beyond range");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && surf_q == '0 && max_q == '0 && state_q == B_IDLE))
    else $error("totals not cleared on emit");

endmodule

// File: hw/rtl/facet_overhang_area_accumulator.sv
`timescale 1ns / 1ps
// Facet overhang and area accumulator.
// Input channel (in_valid_i/in_ready_o/in_data_i): one triangle per beat, three
// vertices in signed Q16.16 mm plus a last_facet flag closing the mesh.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per mesh, sent on
// the last facet: surface, overhang, steep and footprint areas (Q47.16, saturating)
// and the largest overhang angle in 1/256 degree. Totals clear after each beat.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0: overhang
// limit, 1: bed z) in the same cycle; write only while the block is idle.
// Throughput: a three-stage front end forms the cross product and classifies the
// facet at one beat per cycle into a two-entry queue, stalling while its last
// stage holds a facet and the queue is full. The back end takes one facet at a
// time; for a facet that is not downward or rests on the bed its time is set by
// the bit-serial squaring unit and the one-bit-per-cycle square root, and an
// overhanging one adds normalising, a second square and root, then a 23-step
// CORDIC.
// Reset clears all totals, the queue and the pipeline; the overhang limit returns
// to 45 degrees and bed z to 0. A stalled receiver holds the result register; the
// back end then waits at the next last facet, and the queue backs up to the input.
module facet_overhang_area_accumulator import foa_pkg::*; #(
  parameter int unsigned CoordWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  facet_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output facet_out_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IN_W-1:0]      cfg_wdata_i
);

  logic [ANG_W-1:0]       limit_q;
  logic signed [IN_W-1:0] bed_z_q;

  logic   push, full, fifo_valid, pop;
  facet_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      bed_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OVERHANG_LIMIT: limit_q <= cfg_wdata_i[ANG_W-1:0];
        CFG_BED_Z:          bed_z_q <= signed'(cfg_wdata_i);
        default:            limit_q <= limit_q;
      endcase
    end
  end

  foa_front #(
    .CoordWidth(CoordWidth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .bed_z_i   (bed_z_q),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  foa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .valid_o(fifo_valid),
    .pop_i  (pop),
    .entry_o(pop_entry)
  );

  foa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_valid_i(fifo_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
